[rtl/quadratic_root_solver_core_defines.svh]
// Assertion helpers for the core file, which checks its own logic.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define QRS_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define QRS_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qrs_pkg.sv]
`default_nettype none
package qrs_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int MAG_W         = 32;
    localparam int PROD_W        = 64;
    localparam int DISC_W        = 66;
    localparam int ROOT_W        = 33;
    localparam int NUM_W         = 34;
    localparam int SNUM_W        = 36;
    localparam int DEN_W         = 33;
    localparam int ZB_W          = 16;
    localparam int DB_W          = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [1:0] CASE_NONE  = 2'd0;
    localparam logic [1:0] CASE_TWO   = 2'd1;
    localparam logic [1:0] CASE_EQUAL = 2'd2;
    localparam logic [1:0] CASE_CPLX  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_BAND = 2'd1;

    localparam logic [ZB_W-1:0] ZB_RESET = 16'd1;
    localparam logic [DB_W-1:0] DB_RESET = 32'd4295;

    // Side data that rides along the square root pipeline.
    typedef struct packed {
        logic [1:0]       rc;
        logic             az;
        logic             sa;
        logic             sb;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] ma;
    } t_sq_tag;

    // Side data that rides along the divider pipeline.
    typedef struct packed {
        logic [1:0] rc;
        logic       az;
        logic       neg1;
        logic       neg2;
    } t_dv_tag;
endpackage
`default_nettype wire

[rtl/qrs_in_if.sv]
`default_nettype none
interface qrs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [qrs_pkg::COEF_W-1:0] coef_a;
    logic signed [qrs_pkg::COEF_W-1:0] coef_b;
    logic signed [qrs_pkg::COEF_W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

[rtl/qrs_out_if.sv]
`default_nettype none
interface qrs_out_if;
    logic                              valid;
    logic                              ready;
    logic        [1:0]                 root_case;
    logic signed [qrs_pkg::COEF_W-1:0] first_value;
    logic signed [qrs_pkg::COEF_W-1:0] second_value;
    logic                              saturated;

    modport source (output valid, output root_case, output first_value,
                    output second_value, output saturated, input ready);
    modport sink   (input valid, input root_case, input first_value,
                    input second_value, input saturated, output ready);
endinterface
`default_nettype wire

[rtl/qrs_sqrt.sv]
`default_nettype none
// Integer square root, one result bit per pipeline stage.
module qrs_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [qrs_pkg::DISC_W-1:0]   i_rad,
    input  wire qrs_pkg::t_sq_tag             i_tag,
    output logic                              o_valid,
    output logic      [qrs_pkg::ROOT_W-1:0]   o_root,
    output qrs_pkg::t_sq_tag                  o_tag
);
    localparam int N     = qrs_pkg::ROOT_W;
    localparam int REM_W = qrs_pkg::ROOT_W + 3;

    logic [qrs_pkg::DISC_W-1:0] s_rad  [N+1];
    logic [REM_W-1:0]           s_rem  [N+1];
    logic [qrs_pkg::ROOT_W-1:0] s_root [N+1];
    logic                       s_v    [N+1];
    qrs_pkg::t_sq_tag           s_tag  [N+1];

    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_v[0]    = i_valid;
    assign s_tag[0]  = i_tag;

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        logic [REM_W-1:0]           w_rem;
        logic [REM_W-1:0]           w_trial;
        logic                       w_ge;
        logic [qrs_pkg::DISC_W-1:0] r_rad;
        logic [REM_W-1:0]           r_rem;
        logic [qrs_pkg::ROOT_W-1:0] r_root;
        logic                       r_v;
        qrs_pkg::t_sq_tag           r_tag;

        // Bring down the next two radicand bits and try a one in the root.
        assign w_rem   = {s_rem[k][REM_W-3:0], s_rad[k][qrs_pkg::DISC_W-1 -: 2]};
        assign w_trial = {1'b0, s_root[k], 2'b01};
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {s_rad[k][qrs_pkg::DISC_W-3:0], 2'b00};
                r_rem  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_root <= {s_root[k][qrs_pkg::ROOT_W-2:0], w_ge};
                r_tag  <= s_tag[k];
            end
        end

        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_v[k+1]    = r_v;
        assign s_tag[k+1]  = r_tag;
    end

    assign o_valid = s_v[N];
    assign o_root  = s_root[N];
    assign o_tag   = s_tag[N];
endmodule
`default_nettype wire

[rtl/qrs_div.sv]
`default_nettype none
// Two restoring dividers sharing one divisor, one quotient bit per stage.
// Each quotient is (num << FRAC_BITS) / den.
module qrs_div #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic [qrs_pkg::NUM_W-1:0]              i_num1,
    input  wire logic [qrs_pkg::NUM_W-1:0]              i_num2,
    input  wire logic [qrs_pkg::DEN_W-1:0]              i_den,
    input  wire qrs_pkg::t_dv_tag                       i_tag,
    output logic                                        o_valid,
    output logic      [qrs_pkg::NUM_W+FRAC_BITS-1:0]    o_q1,
    output logic      [qrs_pkg::NUM_W+FRAC_BITS-1:0]    o_q2,
    output qrs_pkg::t_dv_tag                            o_tag
);
    localparam int QW = qrs_pkg::NUM_W + FRAC_BITS;
    localparam int DW = qrs_pkg::DEN_W;

    // The dividend shifts out at the top while quotient bits shift in below.
    logic [QW-1:0]    s_x   [QW+1][2];
    logic [DW-1:0]    s_rem [QW+1][2];
    logic [DW-1:0]    s_den [QW+1];
    logic             s_v   [QW+1];
    qrs_pkg::t_dv_tag s_tag [QW+1];

    assign s_x[0][0]   = {i_num1, {FRAC_BITS{1'b0}}};
    assign s_x[0][1]   = {i_num2, {FRAC_BITS{1'b0}}};
    assign s_rem[0][0] = '0;
    assign s_rem[0][1] = '0;
    assign s_den[0]    = i_den;
    assign s_v[0]      = i_valid;
    assign s_tag[0]    = i_tag;

    genvar k, l;
    for (k = 0; k < QW; k++) begin : g_stage
        logic             r_v;
        logic [DW-1:0]    r_den;
        qrs_pkg::t_dv_tag r_tag;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den <= s_den[k];
                r_tag <= s_tag[k];
            end
        end

        assign s_v[k+1]   = r_v;
        assign s_den[k+1] = r_den;
        assign s_tag[k+1] = r_tag;

        for (l = 0; l < 2; l++) begin : g_lane
            logic [DW:0]   w_r;
            logic [DW:0]   w_d;
            logic          w_ge;
            logic [QW-1:0] r_x;
            logic [DW-1:0] r_rem;

            assign w_r  = {s_rem[k][l], s_x[k][l][QW-1]};
            assign w_ge = (w_r >= {1'b0, s_den[k]});
            assign w_d  = w_ge ? (w_r - {1'b0, s_den[k]}) : w_r;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x   <= {s_x[k][l][QW-2:0], w_ge};
                    r_rem <= w_d[DW-1:0];
                end
            end

            assign s_x[k+1][l]   = r_x;
            assign s_rem[k+1][l] = r_rem;
        end
    end

    assign o_valid = s_v[QW];
    assign o_q1    = s_x[QW][0];
    assign o_q2    = s_x[QW][1];
    assign o_tag   = s_tag[QW];
endmodule
`default_nettype wire

[rtl/quadratic_root_solver_core.sv]
// Quadratic root solver. Coefficient items (a, b, c in signed fixed point
// with FRAC_BITS fraction bits) arrive on i_coef; one result item per
// coefficient item leaves on o_root, in order: the case code, two values
// and a saturation flag. Both channels move an item when valid and ready
// are high at a clock edge.
// Throughput is one item per cycle while the skid register is empty.
// The accepting edge loads the first of five front stages for capture, snap,
// multiply, discriminant and classification; then come 33 square root stages,
// one numerator stage, 34 + FRAC_BITS divider stages, a clamp stage and the
// output register.
// zero_band and disc_band are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while no item is in flight,
// which the block itself does not enforce. Writes to other indexes are dropped.
// Reset empties the pipeline and restores zero_band to 1 and disc_band to 4295.
// When the receiver stalls, one more item is caught in a skid register and
// the whole pipeline then holds; nothing is dropped or repeated.
`default_nettype none
`include "quadratic_root_solver_core_defines.svh"
module quadratic_root_solver_core #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    qrs_in_if.sink                                 i_coef,
    qrs_out_if.source                              o_root,
    input  wire logic                              i_cfg_we,
    input  wire logic [qrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int QW = qrs_pkg::NUM_W + FRAC_BITS;
    localparam int MW = qrs_pkg::MAG_W;
    localparam int DW = qrs_pkg::DISC_W;
    localparam int SW = qrs_pkg::SNUM_W;

    typedef struct packed {
        logic [1:0]    rc;
        logic [MW-1:0] v1;
        logic [MW-1:0] v2;
        logic          sat;
    } t_res;

    function automatic logic [MW-1:0] f_mag(input logic [MW-1:0] x);
        f_mag = x[MW-1] ? ({MW{1'b0}} - x) : x;
    endfunction

    // Configuration.
    logic [qrs_pkg::ZB_W-1:0] r_zero_band;
    logic [qrs_pkg::DB_W-1:0] r_disc_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_band <= qrs_pkg::ZB_RESET;
            r_disc_band <= qrs_pkg::DB_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == qrs_pkg::REG_ZERO_BAND) begin
                r_zero_band <= i_cfg_data[qrs_pkg::ZB_W-1:0];
            end
            if (i_cfg_idx == qrs_pkg::REG_DISC_BAND) begin
                r_disc_band <= i_cfg_data[qrs_pkg::DB_W-1:0];
            end
        end
    end

    logic [MW-1:0] w_zb;
    assign w_zb = {{(MW - qrs_pkg::ZB_W){1'b0}}, r_zero_band};

    // The pipeline advances unless the skid register holds an item.
    logic r_skid_v;
    logic w_en;
    assign w_en         = !r_skid_v;
    assign i_coef.ready = w_en;

    // Stage 1: capture.
    logic          r1_v;
    logic [MW-1:0] r1_a, r1_b, r1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_coef.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= i_coef.coef_a;
            r1_b <= i_coef.coef_b;
            r1_c <= i_coef.coef_c;
        end
    end

    // Stage 2: sign and magnitude, with the zero band applied.
    logic          r2_v, r2_sa, r2_sb, r2_sc;
    logic [MW-1:0] r2_ma, r2_mb, r2_mc;
    logic [MW-1:0] w_ma, w_mb, w_mc;
    logic          w_za, w_zb_b, w_zc;

    assign w_ma   = f_mag(r1_a);
    assign w_mb   = f_mag(r1_b);
    assign w_mc   = f_mag(r1_c);
    assign w_za   = (w_ma < w_zb);
    assign w_zb_b = (w_mb < w_zb);
    assign w_zc   = (w_mc < w_zb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ma <= w_za ? '0 : w_ma;
            r2_mb <= w_zb_b ? '0 : w_mb;
            r2_mc <= w_zc ? '0 : w_mc;
            r2_sa <= r1_a[MW-1] && !w_za;
            r2_sb <= r1_b[MW-1] && !w_zb_b;
            r2_sc <= r1_c[MW-1] && !w_zc;
        end
    end

    // Stage 3: b squared and a times c.
    logic                       r3_v, r3_sa, r3_sb, r3_sc, r3_cz;
    logic [MW-1:0]              r3_ma, r3_mb;
    logic [qrs_pkg::PROD_W-1:0] r3_bb, r3_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_bb <= {{MW{1'b0}}, r2_mb} * {{MW{1'b0}}, r2_mb};
            r3_ac <= {{MW{1'b0}}, r2_ma} * {{MW{1'b0}}, r2_mc};
            r3_ma <= r2_ma;
            r3_mb <= r2_mb;
            r3_sa <= r2_sa;
            r3_sb <= r2_sb;
            r3_sc <= r2_sc;
            r3_cz <= (r2_mc == '0);
        end
    end

    // Stage 4: discriminant as sign and magnitude.
    logic          r4_v, r4_sa, r4_sb, r4_dneg;
    logic [MW-1:0] r4_ma, r4_mb;
    logic [DW-1:0] r4_d;
    logic [DW-1:0] w_p, w_b, w_add, w_bp, w_pb;
    logic          w_ge, w_mixed;

    assign w_p     = {r3_ac, 2'b00};
    assign w_b     = {2'b00, r3_bb};
    assign w_add   = w_b + w_p;
    assign w_bp    = w_b - w_p;
    assign w_pb    = w_p - w_b;
    assign w_ge    = (w_b >= w_p);
    // With a and c of opposite sign, -4ac is positive and the terms add.
    assign w_mixed = (r3_sa != r3_sc) && !r3_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_d    <= w_mixed ? w_add : (w_ge ? w_bp : w_pb);
            r4_dneg <= !w_mixed && !w_ge;
            r4_ma   <= r3_ma;
            r4_mb   <= r3_mb;
            r4_sa   <= r3_sa;
            r4_sb   <= r3_sb;
        end
    end

    // Stage 5: classification.
    logic             r5_v;
    logic [DW-1:0]    r5_d;
    qrs_pkg::t_sq_tag r5_tag;
    logic             w_big, w_az;
    logic [1:0]       w_rc;

    assign w_big = (r4_d > {{(DW - qrs_pkg::DB_W){1'b0}}, r_disc_band});
    assign w_az  = (r4_ma == '0);

    always_comb begin
        if (w_az) begin
            w_rc = qrs_pkg::CASE_NONE;
        end else if (w_big && !r4_dneg) begin
            w_rc = qrs_pkg::CASE_TWO;
        end else if (w_big) begin
            w_rc = qrs_pkg::CASE_CPLX;
        end else begin
            w_rc = qrs_pkg::CASE_EQUAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_d       <= r4_d;
            r5_tag.rc  <= w_rc;
            r5_tag.az  <= w_az;
            r5_tag.sa  <= r4_sa;
            r5_tag.sb  <= r4_sb;
            r5_tag.mb  <= r4_mb;
            r5_tag.ma  <= r4_ma;
        end
    end

    // Square root of the discriminant magnitude.
    logic                       w_sq_v;
    logic [qrs_pkg::ROOT_W-1:0] w_sq_root;
    qrs_pkg::t_sq_tag           w_sq_tag;

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_rad   (r5_d),
        .i_tag   (r5_tag),
        .o_valid (w_sq_v),
        .o_root  (w_sq_root),
        .o_tag   (w_sq_tag)
    );

    // Stage 6: numerators as sign and magnitude, divisor 2a.
    logic                       r6_v;
    logic [qrs_pkg::NUM_W-1:0]  r6_n1, r6_n2;
    logic [qrs_pkg::DEN_W-1:0]  r6_den;
    qrs_pkg::t_dv_tag           r6_tag;
    logic [SW-1:0]              w_nb, w_s, w_n1, w_n2, w_a1, w_a2;

    assign w_nb = w_sq_tag.sb ? {{(SW - MW){1'b0}}, w_sq_tag.mb}
                              : ({SW{1'b0}} - {{(SW - MW){1'b0}}, w_sq_tag.mb});
    assign w_s  = {{(SW - qrs_pkg::ROOT_W){1'b0}}, w_sq_root};

    always_comb begin
        case (w_sq_tag.rc)
            qrs_pkg::CASE_TWO: begin
                w_n1 = w_nb + w_s;
                w_n2 = w_nb - w_s;
            end
            qrs_pkg::CASE_CPLX: begin
                w_n1 = w_nb;
                w_n2 = w_s;
            end
            default: begin
                w_n1 = w_nb;
                w_n2 = w_nb;
            end
        endcase
    end

    assign w_a1 = w_n1[SW-1] ? ({SW{1'b0}} - w_n1) : w_n1;
    assign w_a2 = w_n2[SW-1] ? ({SW{1'b0}} - w_n2) : w_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_n1       <= w_a1[qrs_pkg::NUM_W-1:0];
            r6_n2       <= w_a2[qrs_pkg::NUM_W-1:0];
            r6_den      <= {w_sq_tag.ma, 1'b0};
            r6_tag.rc   <= w_sq_tag.rc;
            r6_tag.az   <= w_sq_tag.az;
            r6_tag.neg1 <= w_n1[SW-1] ^ w_sq_tag.sa;
            // The imaginary magnitude is always taken as positive.
            r6_tag.neg2 <= (w_sq_tag.rc == qrs_pkg::CASE_CPLX) ? 1'b0
                                                               : (w_n2[SW-1] ^ w_sq_tag.sa);
        end
    end

    // Quotients.
    logic             w_dv_v;
    logic [QW-1:0]    w_q1, w_q2;
    qrs_pkg::t_dv_tag w_dv_tag;

    qrs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_num1  (r6_n1),
        .i_num2  (r6_n2),
        .i_den   (r6_den),
        .i_tag   (r6_tag),
        .o_valid (w_dv_v),
        .o_q1    (w_q1),
        .o_q2    (w_q2),
        .o_tag   (w_dv_tag)
    );

    // Stage 7: clamp to the 32-bit range.
    logic          r7_v, r7_neg1, r7_neg2, r7_sat, r7_az;
    logic [1:0]    r7_rc;
    logic [MW-1:0] r7_m1, r7_m2;
    logic [MW-1:0] w_lim1, w_lim2;
    logic          w_ov1, w_ov2;

    assign w_lim1 = w_dv_tag.neg1 ? {1'b1, {(MW - 1){1'b0}}} : {1'b0, {(MW - 1){1'b1}}};
    assign w_lim2 = w_dv_tag.neg2 ? {1'b1, {(MW - 1){1'b0}}} : {1'b0, {(MW - 1){1'b1}}};
    assign w_ov1  = (w_q1 > {{(QW - MW){1'b0}}, w_lim1});
    assign w_ov2  = (w_q2 > {{(QW - MW){1'b0}}, w_lim2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_m1   <= w_ov1 ? w_lim1 : w_q1[MW-1:0];
            r7_m2   <= w_ov2 ? w_lim2 : w_q2[MW-1:0];
            r7_neg1 <= w_dv_tag.neg1;
            r7_neg2 <= w_dv_tag.neg2;
            r7_sat  <= (w_ov1 || w_ov2) && !w_dv_tag.az;
            r7_az   <= w_dv_tag.az;
            r7_rc   <= w_dv_tag.rc;
        end
    end

    // Zero band on the results and sign restore.
    t_res w_res;

    always_comb begin
        w_res.rc  = r7_rc;
        w_res.sat = r7_sat;
        if (r7_az || (r7_m1 < w_zb)) begin
            w_res.v1 = '0;
        end else begin
            w_res.v1 = r7_neg1 ? ({MW{1'b0}} - r7_m1) : r7_m1;
        end
        if (r7_az || (r7_m2 < w_zb)) begin
            w_res.v2 = '0;
        end else begin
            w_res.v2 = r7_neg2 ? ({MW{1'b0}} - r7_m2) : r7_m2;
        end
    end

    // Output register with a skid register behind it.
    logic r_ov;
    t_res r_out, r_skid;
    logic w_take;

    assign w_take = r_ov && o_root.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r7_v) begin
            if (r_ov && !w_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r7_v) begin
            if (r_ov && !w_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_root.valid        = r_ov;
    assign o_root.root_case    = r_out.rc;
    assign o_root.first_value  = r_out.v1;
    assign o_root.second_value = r_out.v2;
    assign o_root.saturated    = r_out.sat;

    `QRS_ASSERT_IMP(a_skid_needs_out, r_skid_v, r_ov, "skid holds an item with no output item")
    `QRS_ASSERT_NXT(a_skid_holds, r_skid_v && !o_root.ready, r_skid_v,
                    "skid item lost while the receiver stalls")
    `QRS_ASSERT_IMP(a_none_zero,
                    r_ov && (r_out.rc == qrs_pkg::CASE_NONE),
                    (r_out.v1 == '0) && (r_out.v2 == '0) && !r_out.sat,
                    "not-quadratic item carries nonzero values")
    `QRS_ASSERT_IMP(a_equal_same,
                    r_ov && (r_out.rc == qrs_pkg::CASE_EQUAL),
                    r_out.v1 == r_out.v2,
                    "equal-root item carries two different values")
endmodule
`default_nettype wire
